// ----- rtl/core/spc_pkg.sv -----
// ---------------------------------------------------------------------------
// spc_pkg: shared types and constants of the skin pixel classifier
// Pixel and result payloads, configuration set, stage link and the fixed
// coefficients of the elliptical skin-colour model.
// ---------------------------------------------------------------------------
package spc_pkg;

	localparam int REG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 18;
	localparam int DIST_W      = 18;

	// ellipse rotation: u = (819*cr - 614*cb)/32 + 51, v = (819*cr + 614*cb)/32 + 77
	localparam int ROT_CR_K    = 819;
	localparam int ROT_CB_K    = 614;
	localparam int ROT_SHIFT   = 5;
	localparam int ROT_BIAS    = (1 << ROT_SHIFT) - 1;
	localparam int U_OFFSET    = 51;
	localparam int V_OFFSET    = 77;

	// axis scaling: x = u*41/1024, y = v*73/1024
	localparam int X_SCALE     = 41;
	localparam int Y_SCALE     = 73;
	localparam int SCALE_SHIFT = 10;
	localparam int SCALE_BIAS  = (1 << SCALE_SHIFT) - 1;

	localparam int DIST_MAX    = (1 << DIST_W) - 1;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_CB_CENTER    = 8'd0,
		REG_CR_CENTER    = 8'd1,
		REG_LUMA_SPLIT   = 8'd2,
		REG_DARK_LIMIT   = 8'd3,
		REG_BRIGHT_LIMIT = 8'd4,
		REG_WHITE_LEVEL  = 8'd5,
		REG_WHITE_SPREAD = 8'd6
	} reg_index_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] chroma_red;
		logic [7:0] chroma_blue;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic              is_skin;
		logic [DIST_W-1:0] ellipse_distance;
	} result_t;

	typedef struct packed {
		logic [7:0]        cb_center;
		logic [7:0]        cr_center;
		logic [7:0]        luma_split;
		logic [DIST_W-1:0] dark_limit;
		logic [DIST_W-1:0] bright_limit;
		logic [7:0]        white_level;
		logic [7:0]        white_spread;
	} cfg_t;

	// rotated coordinates plus side flags, between rotation and distance parts
	typedef struct packed {
		logic               valid;
		logic signed [14:0] u;
		logic signed [14:0] v;
		logic               dark;
		logic               white;
	} rot_t;

endpackage

// ----- rtl/core/spc_stream_if.sv -----
// ---------------------------------------------------------------------------
// spc_stream_if: valid/ready stream channel
// Carries one payload of type T per transfer; source drives valid and data,
// sink drives ready.
// ---------------------------------------------------------------------------
interface spc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/skin_pixel_classifier_top.sv -----
// ---------------------------------------------------------------------------
// skin_pixel_classifier_top: elliptical YCbCr skin-colour classifier
// Throughput: one pixel per cycle while the sink accepts results; five
// registered stages, each with its own enable, so a stalled sink holds the
// pipe without losing bubbles' space.
// Reset: clears all stage valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
module skin_pixel_classifier_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [spc_pkg::REG_INDEX_W-1:0]    wr_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0]     wr_data,
	spc_stream_if.sink                         pix,
	spc_stream_if.source                       res
);

	spc_pkg::cfg_t cfg_q;
	spc_pkg::rot_t rot_s2;
	logic          rot_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cb_center    <= 8'd109;
			cfg_q.cr_center    <= 8'd152;
			cfg_q.luma_split   <= 8'd100;
			cfg_q.dark_limit   <= 18'd700;
			cfg_q.bright_limit <= 18'd850;
			cfg_q.white_level  <= 8'd160;
			cfg_q.white_spread <= 8'd30;
		end else if (wr_en) begin
			// drop writes beyond the register list
			unique case (spc_pkg::reg_index_t'(wr_index))
				spc_pkg::REG_CB_CENTER:    cfg_q.cb_center    <= wr_data[7:0];
				spc_pkg::REG_CR_CENTER:    cfg_q.cr_center    <= wr_data[7:0];
				spc_pkg::REG_LUMA_SPLIT:   cfg_q.luma_split   <= wr_data[7:0];
				spc_pkg::REG_DARK_LIMIT:   cfg_q.dark_limit   <= wr_data;
				spc_pkg::REG_BRIGHT_LIMIT: cfg_q.bright_limit <= wr_data;
				spc_pkg::REG_WHITE_LEVEL:  cfg_q.white_level  <= wr_data[7:0];
				spc_pkg::REG_WHITE_SPREAD: cfg_q.white_spread <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	spc_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix.valid),
		.pix_data  (pix.data),
		.pix_ready (pix.ready),
		.rot_s2    (rot_s2),
		.rot_ready (rot_ready)
	);

	spc_distance u_distance (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rot       (rot_s2),
		.rot_ready (rot_ready),
		.res_valid (res.valid),
		.res_data  (res.data),
		.res_ready (res.ready)
	);

	// a ready sink lets every stage advance, so the input must be ready too
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		res.ready |-> pix.ready)
		else $error("input stalled while output sink is ready");

	a_empty_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> pix.ready)
		else $error("input stalled while output stage is empty");

	a_skin_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.is_skin) |->
		((res.data.ellipse_distance < cfg_q.dark_limit) ||
		 (res.data.ellipse_distance < cfg_q.bright_limit)))
		else $error("skin reported with distance above both limits");

endmodule

// ----- rtl/core/spc_rotate.sv -----
// ---------------------------------------------------------------------------
// spc_rotate: chroma centring and ellipse rotation (stages 1 and 2)
// Stage 1 centres Cr/Cb and forms the constant products plus the white and
// luma flags; stage 2 combines them into truncated u and v.
// ---------------------------------------------------------------------------
module spc_rotate (
	input  logic            clk,
	input  logic            arst_n,
	input  spc_pkg::cfg_t   cfg,
	input  logic            pix_valid,
	input  spc_pkg::pixel_t pix_data,
	output logic            pix_ready,
	output spc_pkg::rot_t   rot_s2,
	input  logic            rot_ready
);

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? a - b : b - a;
	endfunction

	logic               valid_s1;
	logic signed [18:0] p_cr_s1;
	logic signed [18:0] p_cb_s1;
	logic               dark_s1;
	logic               white_s1;

	logic               valid_s2;
	logic signed [14:0] u_s2;
	logic signed [14:0] v_s2;
	logic               dark_s2;
	logic               white_s2;

	logic               en_s1;
	logic               en_s2;

	logic signed [8:0]  cr_c;
	logic signed [8:0]  cb_c;
	logic               white_w;
	logic signed [19:0] sum_u;
	logic signed [19:0] sum_v;
	logic signed [19:0] div_u;
	logic signed [19:0] div_v;

	assign en_s2     = !valid_s2 || rot_ready;
	assign en_s1     = !valid_s1 || en_s2;
	assign pix_ready = en_s1;
	assign rot_s2    = '{valid: valid_s2, u: u_s2, v: v_s2, dark: dark_s2, white: white_s2};

	always_comb begin
		cr_c = $signed({1'b0, pix_data.chroma_red}) - $signed({1'b0, cfg.cr_center});
		cb_c = $signed({1'b0, pix_data.chroma_blue}) - $signed({1'b0, cfg.cb_center});
		white_w = (pix_data.blue > cfg.white_level) && (pix_data.green > cfg.white_level) &&
			(pix_data.red > cfg.white_level) &&
			(abs_diff(pix_data.blue, pix_data.green) <= cfg.white_spread) &&
			(abs_diff(pix_data.blue, pix_data.red) <= cfg.white_spread) &&
			(abs_diff(pix_data.green, pix_data.red) <= cfg.white_spread);
	end

	// truncate toward zero: bias negative sums before the arithmetic shift
	always_comb begin
		sum_u = 20'(p_cr_s1) - 20'(p_cb_s1);
		sum_v = 20'(p_cr_s1) + 20'(p_cb_s1);
		div_u = (sum_u + (sum_u[19] ? 20'(spc_pkg::ROT_BIAS) : 20'sd0)) >>> spc_pkg::ROT_SHIFT;
		div_v = (sum_v + (sum_v[19] ? 20'(spc_pkg::ROT_BIAS) : 20'sd0)) >>> spc_pkg::ROT_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= pix_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			p_cr_s1  <= 19'(cr_c) * 19'(spc_pkg::ROT_CR_K);
			p_cb_s1  <= 19'(cb_c) * 19'(spc_pkg::ROT_CB_K);
			dark_s1  <= pix_data.luma < cfg.luma_split;
			white_s1 <= white_w;
		end
		if (en_s2) begin
			u_s2     <= 15'(div_u) + 15'(spc_pkg::U_OFFSET);
			v_s2     <= 15'(div_v) + 15'(spc_pkg::V_OFFSET);
			dark_s2  <= dark_s1;
			white_s2 <= white_s1;
		end
	end

endmodule

// ----- rtl/core/spc_distance.sv -----
// ---------------------------------------------------------------------------
// spc_distance: axis scaling, squared distance and decision (stages 3 to 5)
// Stage 3 scales u and v, stage 4 squares them, stage 5 sums, tests against
// the selected limit and white flag, saturates, holds result for the sink.
// ---------------------------------------------------------------------------
module spc_distance (
	input  logic             clk,
	input  logic             arst_n,
	input  spc_pkg::cfg_t    cfg,
	input  spc_pkg::rot_t    rot,
	output logic             rot_ready,
	output logic             res_valid,
	output spc_pkg::result_t res_data,
	input  logic             res_ready
);

	logic               valid_s3;
	logic signed [9:0]  x_s3;
	logic signed [10:0] y_s3;
	logic               dark_s3;
	logic               white_s3;

	logic               valid_s4;
	logic [17:0]        xsq_s4;
	logic [19:0]        ysq_s4;
	logic               dark_s4;
	logic               white_s4;

	logic               valid_s5;
	spc_pkg::result_t   res_s5;

	logic               en_s3;
	logic               en_s4;
	logic               en_s5;

	logic signed [19:0] ux;
	logic signed [20:0] vy;
	logic signed [19:0] x_w;
	logic signed [20:0] y_w;
	logic [19:0]        d;
	logic [19:0]        limit;

	assign en_s5     = !valid_s5 || res_ready;
	assign en_s4     = !valid_s4 || en_s5;
	assign en_s3     = !valid_s3 || en_s4;
	assign rot_ready = en_s3;
	assign res_valid = valid_s5;
	assign res_data  = res_s5;

	always_comb begin
		ux  = 20'(rot.u) * 20'(spc_pkg::X_SCALE);
		vy  = 21'(rot.v) * 21'(spc_pkg::Y_SCALE);
		x_w = (ux + (ux[19] ? 20'(spc_pkg::SCALE_BIAS) : 20'sd0)) >>> spc_pkg::SCALE_SHIFT;
		y_w = (vy + (vy[20] ? 21'(spc_pkg::SCALE_BIAS) : 21'sd0)) >>> spc_pkg::SCALE_SHIFT;
	end

	// compare at full width; the limits never exceed the saturated range
	always_comb begin
		d     = 20'(xsq_s4) + ysq_s4;
		limit = dark_s4 ? 20'(cfg.dark_limit) : 20'(cfg.bright_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s3)
				valid_s3 <= rot.valid;
			if (en_s4)
				valid_s4 <= valid_s3;
			if (en_s5)
				valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			x_s3     <= 10'(x_w);
			y_s3     <= 11'(y_w);
			dark_s3  <= rot.dark;
			white_s3 <= rot.white;
		end
		if (en_s4) begin
			xsq_s4   <= 18'(19'(x_s3) * 19'(x_s3));
			ysq_s4   <= 20'(21'(y_s3) * 21'(y_s3));
			dark_s4  <= dark_s3;
			white_s4 <= white_s3;
		end
		if (en_s5) begin
			res_s5.is_skin <= (d < limit) && !white_s4;
			res_s5.ellipse_distance <= (d > 20'(spc_pkg::DIST_MAX)) ?
				spc_pkg::DIST_W'(spc_pkg::DIST_MAX) : spc_pkg::DIST_W'(d);
		end
	end

endmodule
